/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* src/ce3m_pkg.sv */
// ----------------------------------------------------------------------------
// ce3m_pkg
// Types, constants and response functions of the compass edge unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ce3m_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_WIDTH_W = 11;
    localparam int MIN_DIM     = 3;
    localparam int MAX_HEIGHT  = 4096;
    localparam int RST_WIDTH   = 640;
    localparam int RST_HEIGHT  = 480;
    localparam int SUM_W       = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t win;
        logic    last;
    } win_item_t;

    typedef logic [3:0][SUM_W-1:0] resp_t;

    // |pos - neg| of two 10-bit sums
    function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] pos,
                                                  input logic [SUM_W-1:0] neg);
        abs_diff = (pos >= neg) ? (pos - neg) : (neg - pos);
    endfunction

    function automatic logic [SUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b2,
                                              input logic [PIX_W-1:0] c);
        wsum = SUM_W'(a) + {1'b0, b2, 1'b0} + SUM_W'(c);
    endfunction

    // Magnitudes of the four base masks; the other four are their negations.
    function automatic resp_t compass_abs(input window_t w);
        resp_t r;
        r[0] = abs_diff(wsum(w[0], w[1], w[2]), wsum(w[6], w[7], w[8]));
        r[1] = abs_diff(wsum(w[1], w[0], w[3]), wsum(w[5], w[8], w[7]));
        r[2] = abs_diff(wsum(w[0], w[3], w[6]), wsum(w[2], w[5], w[8]));
        r[3] = abs_diff(wsum(w[3], w[6], w[7]), wsum(w[1], w[2], w[5]));
        compass_abs = r;
    endfunction

endpackage

/* src/ce3m_ram.sv */
// ----------------------------------------------------------------------------
// ce3m_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce3m_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ce3m_front.sv */
// ----------------------------------------------------------------------------
// ce3m_front
// Frame counters, line buffer and 3x3 window; queues interior windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce3m_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ce3m_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ce3m_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ce3m_pkg::PIX_W-1:0]      pixel,
    input  logic [ce3m_pkg::QCNT_W-1:0]     q_count,
    output logic                            push,
    output ce3m_pkg::win_item_t             push_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = ce3m_pkg::ROW_W;
    localparam int DW = ce3m_pkg::CFG_DATA_W;
    localparam int PW = ce3m_pkg::PIX_W;
    localparam int RST_W_EFF = (MAX_WIDTH < ce3m_pkg::RST_WIDTH) ? MAX_WIDTH
                                                                 : ce3m_pkg::RST_WIDTH;

    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic [PW-1:0] s1_px_reg;
    ce3m_pkg::window_t window_reg, window_next;
    logic [DW-1:0] wv;
    logic [2*PW-1:0] rd_data;
    logic          accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = ((ce3m_pkg::QCNT_W + 1)'(q_count) + (ce3m_pkg::QCNT_W + 1)'(s1_valid_reg))
                      < (ce3m_pkg::QCNT_W + 1)'(ce3m_pkg::QUEUE_DEPTH);
    assign wv       = DW'(cfg_data[ce3m_pkg::CFG_WIDTH_W-1:0]);

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                ce3m_pkg::REG_IMAGE_WIDTH:
                begin
                    if (wv < DW'(ce3m_pkg::MIN_DIM))
                        w_last_next = CW'(ce3m_pkg::MIN_DIM - 1);
                    else if (wv > DW'(MAX_WIDTH))
                        w_last_next = CW'(MAX_WIDTH - 1);
                    else
                        w_last_next = CW'(wv - DW'(1));
                    col_next = '0;
                    row_next = '0;
                end
                ce3m_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data < DW'(ce3m_pkg::MIN_DIM))
                        h_last_next = RW'(ce3m_pkg::MIN_DIM - 1);
                    else if (cfg_data > DW'(ce3m_pkg::MAX_HEIGHT))
                        h_last_next = RW'(ce3m_pkg::MAX_HEIGHT - 1);
                    else
                        h_last_next = RW'(cfg_data - DW'(1));
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_reg == w_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= CW'(RST_W_EFF - 1);
            h_last_reg   <= RW'(ce3m_pkg::RST_HEIGHT - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            w_last_reg   <= w_last_next;
            h_last_reg   <= h_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_emit_reg <= (row_reg >= RW'(2)) && (col_reg >= CW'(2));
                s1_last_reg <= (row_reg == h_last_reg) && (col_reg == w_last_reg);
            end
            if (s1_valid_reg)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_reg;
            s1_px_reg  <= pixel;
        end
    end

    // rd_data: [15:8] row r-2, [7:0] row r-1
    ce3m_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({rd_data[PW-1:0], s1_px_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = rd_data[2*PW-1:PW];
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = rd_data[PW-1:0];
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = s1_px_reg;
    end

    assign push           = s1_valid_reg && s1_emit_reg;
    assign push_item.win  = window_next;
    assign push_item.last = s1_last_reg;

endmodule

/* src/ce3m_queue.sv */
// ----------------------------------------------------------------------------
// ce3m_queue
// Small FIFO of windows between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce3m_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  ce3m_pkg::win_item_t         push_item,
    input  logic                        pop,
    output logic                        pop_valid,
    output ce3m_pkg::win_item_t         pop_item,
    output logic [ce3m_pkg::QCNT_W-1:0] count
);

    ce3m_pkg::win_item_t                 slot_reg [ce3m_pkg::QUEUE_DEPTH];
    logic [ce3m_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [ce3m_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [ce3m_pkg::QCNT_W-1:0]         count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + ce3m_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + ce3m_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + ce3m_pkg::QCNT_W'(push) - ce3m_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

/* src/ce3m_back.sv */
// ----------------------------------------------------------------------------
// ce3m_back
// Mask responses, maximum and clamp, with a stallable output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ce3m_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  ce3m_pkg::win_item_t        q_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ce3m_pkg::PIX_W-1:0] edge_strength,
    output logic                       frame_last
);

    localparam int SW = ce3m_pkg::SUM_W;

    logic                       b1_valid_reg, b1_last_reg;
    ce3m_pkg::resp_t            b1_resp_reg;
    logic                       o_valid_reg, o_last_reg;
    logic [ce3m_pkg::PIX_W-1:0] o_edge_reg;
    logic                       o_load, b1_load;
    logic [SW-1:0]              max01, max23, max_all;

    assign o_load  = b1_valid_reg && (!o_valid_reg || out_ready);
    assign b1_load = !b1_valid_reg || o_load;
    assign pop     = q_valid && b1_load;

    assign max01   = (b1_resp_reg[0] > b1_resp_reg[1]) ? b1_resp_reg[0] : b1_resp_reg[1];
    assign max23   = (b1_resp_reg[2] > b1_resp_reg[3]) ? b1_resp_reg[2] : b1_resp_reg[3];
    assign max_all = (max01 > max23) ? max01 : max23;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (b1_load)
            begin
                b1_valid_reg <= q_valid;
            end
            if (o_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_resp_reg <= ce3m_pkg::compass_abs(q_item.win);
            b1_last_reg <= q_item.last;
        end
        if (o_load)
        begin
            o_edge_reg <= (max_all > SW'(ce3m_pkg::PIX_MAX)) ? ce3m_pkg::PIX_MAX
                                                             : max_all[ce3m_pkg::PIX_W-1:0];
            o_last_reg <= b1_last_reg;
        end
    end

    assign out_valid     = o_valid_reg;
    assign edge_strength = o_edge_reg;
    assign frame_last    = o_last_reg;

endmodule

/* src/compass_edge_3x3_max_unit.sv */
// A window goes via stage-1 regs, the queue, b1 and the output register to out_valid.
// One pixel per cycle while in_ready is high; one line RAM read and write per pixel.
// A 4-entry window queue lets the front keep taking pixels while the output is held.
// Reset: frame counters, window and pipeline valids clear; width 640, height 480.
// The line RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// compass_edge_3x3_max_unit
// 3x3 compass edge detector giving the clamped maximum mask response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module compass_edge_3x3_max_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ce3m_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ce3m_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ce3m_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ce3m_pkg::PIX_W-1:0]      edge_strength,
    output logic                            frame_last
);

    logic                        q_push, q_pop, q_valid;
    ce3m_pkg::win_item_t         q_push_item, q_pop_item;
    logic [ce3m_pkg::QCNT_W-1:0] q_count;

    ce3m_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .q_count   (q_count),
        .push      (q_push),
        .push_item (q_push_item)
    );

    ce3m_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item),
        .count     (q_count)
    );

    ce3m_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_pop_item),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .edge_strength (edge_strength),
        .frame_last    (frame_last)
    );

    `ASSERT_IMPL(a_q_no_overflow, q_push && !q_pop,
                 q_count != ce3m_pkg::QCNT_W'(ce3m_pkg::QUEUE_DEPTH), "window queue overflow")
    `ASSERT_IMPL(a_q_no_underflow, q_pop, q_count != '0, "window queue underflow")
    `ASSERT_IMPL(a_q_count_track, 1'b1,
                 ##1 q_count == $past(q_count) + ce3m_pkg::QCNT_W'($past(q_push))
                     - ce3m_pkg::QCNT_W'($past(q_pop)), "window queue count mismatch")

endmodule

/* sim/compass_edge_3x3_max_unit_test.sv */
// ----------------------------------------------------------------------------
// compass_edge_3x3_max_unit_test
// Self-checking bench for the 3x3 compass edge unit. Pixel items are queued by
// the stimulus block, driven with random gaps and mirrored into a line-buffer
// and window predictor. Each edge result is checked against the oldest
// prediction while the output side stalls at random. Frame sizes are written
// between phases, including sizes below the minimum and above the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compass_edge_3x3_max_unit_test;

    localparam int EDGE_MAX_W   = 1024;
    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYC   = 12;

    localparam logic [ce3m_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [ce3m_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum int {
        STYLE_NOISE,
        STYLE_BINARY,
        STYLE_FLAT
    } pixel_style_t;

    typedef struct packed {
        logic [ce3m_pkg::PIX_W-1:0] strength;
        logic                       last;
    } edge_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wen;
    logic [ce3m_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ce3m_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [ce3m_pkg::PIX_W-1:0]      pixel;
    logic                            out_valid;
    logic                            out_ready;
    logic [ce3m_pkg::PIX_W-1:0]      edge_strength;
    logic                            frame_last;

    logic [ce3m_pkg::PIX_W-1:0] pending_pixels[$];
    edge_result_t               expected_edges[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int cycle_count;

    // predictor state
    logic [ce3m_pkg::PIX_W-1:0] line_mem [0:2*EDGE_MAX_W-1];
    int                         win [9];
    int                         col_pos;
    int                         row_pos;
    int                         width_reg;
    int                         height_reg;

    compass_edge_3x3_max_unit #(
        .MAX_WIDTH(EDGE_MAX_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .edge_strength (edge_strength),
        .frame_last    (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int eff_width();
        return clamp_dim(width_reg, ce3m_pkg::MIN_DIM, EDGE_MAX_W);
    endfunction

    function automatic int eff_height();
        return clamp_dim(height_reg, ce3m_pkg::MIN_DIM, ce3m_pkg::MAX_HEIGHT);
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    // largest magnitude of the four base masks, clamped to a pixel
    function automatic logic [ce3m_pkg::PIX_W-1:0] compass_peak();
        int resp [4];
        int best;
        resp[0] = win[0] + 2*win[1] + win[2] - win[6] - 2*win[7] - win[8];
        resp[1] = 2*win[0] + win[1] + win[3] - win[5] - win[7] - 2*win[8];
        resp[2] = win[0] - win[2] + 2*win[3] - 2*win[5] + win[6] - win[8];
        resp[3] = -win[1] - 2*win[2] + win[3] - win[5] + 2*win[6] + win[7];
        best = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (abs_int(resp[k]) > best)
                best = abs_int(resp[k]);
        end
        if (best > 255)
            best = 255;
        return ce3m_pkg::PIX_W'(best);
    endfunction

    function automatic void apply_reg(logic [ce3m_pkg::CFG_IDX_W-1:0] idx,
                                      logic [ce3m_pkg::CFG_DATA_W-1:0] data);
        if (idx == ce3m_pkg::REG_IMAGE_WIDTH)
            width_reg = int'(data[ce3m_pkg::CFG_WIDTH_W-1:0]);
        else if (idx == ce3m_pkg::REG_IMAGE_HEIGHT)
            height_reg = int'(data);
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void predict_edge(logic [ce3m_pkg::PIX_W-1:0] px);
        int w;
        int h;
        int c;
        int r;
        int ci;
        logic [ce3m_pkg::PIX_W-1:0] top;
        logic [ce3m_pkg::PIX_W-1:0] mid;
        edge_result_t res;
        w = eff_width();
        h = eff_height();
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        ci = c % EDGE_MAX_W;
        top = line_mem[ci];
        mid = line_mem[EDGE_MAX_W + ci];
        line_mem[ci] = mid;
        line_mem[EDGE_MAX_W + ci] = px;
        win[0] = win[1]; win[1] = win[2]; win[2] = int'(top);
        win[3] = win[4]; win[4] = win[5]; win[5] = int'(mid);
        win[6] = win[7]; win[7] = win[8]; win[8] = int'(px);
        if (r >= 2 && c >= 2)
        begin
            res.strength = compass_peak();
            res.last = (r == h - 1 && c == w - 1);
            expected_edges.push_back(res);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_edge(pixel);
            if (!in_valid || in_ready)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    pixel <= pending_pixels.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        edge_result_t exp_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    $error("unexpected item: edge_strength %0d frame_last %0b",
                           edge_strength, frame_last);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expected_edges.pop_front();
                    if (edge_strength !== exp_res.strength)
                    begin
                        $error("edge_strength: expected %0d, actual %0d",
                               exp_res.strength, edge_strength);
                        mismatch_count++;
                    end
                    if (frame_last !== exp_res.last)
                    begin
                        $error("frame_last: expected %0b, actual %0b",
                               exp_res.last, frame_last);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [ce3m_pkg::CFG_IDX_W-1:0] idx,
                             logic [ce3m_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_reg(idx, data);
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic push_pixels(int count, pixel_style_t style);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            case (style)
                STYLE_BINARY: pending_pixels.push_back($urandom_range(0, 1) ? ce3m_pkg::PIX_MAX
                                                                             : 8'd0);
                STYLE_FLAT:   pending_pixels.push_back(ce3m_pkg::PIX_W'($urandom_range(110, 140)));
                default:      pending_pixels.push_back(ce3m_pkg::PIX_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic push_frame3(logic [ce3m_pkg::PIX_W-1:0] a, logic [ce3m_pkg::PIX_W-1:0] b,
                               logic [ce3m_pkg::PIX_W-1:0] c);
        @(negedge clk);
        for (int i = 0; i < 9; i++)
        begin
            if (i < 3)
                pending_pixels.push_back(a);
            else if (i < 6)
                pending_pixels.push_back(b);
            else
                pending_pixels.push_back(c);
        end
    endtask

    initial
    begin
        int random_items;
        int frame_px;
        int count;
        pixel_style_t style;

        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 14;
        recv_idle_pct = 67;
        for (int i = 0; i < 2*EDGE_MAX_W; i++)
            line_mem[i] = '0;
        for (int i = 0; i < 9; i++)
            win[i] = 0;
        col_pos = 0;
        row_pos = 0;
        width_reg = ce3m_pkg::RST_WIDTH;
        height_reg = ce3m_pkg::RST_HEIGHT;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // below-minimum sizes saturate to 3x3
        write_reg(ce3m_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(ce3m_pkg::REG_IMAGE_HEIGHT, 13'd0);
        push_frame3(ce3m_pkg::PIX_MAX, ce3m_pkg::PIX_MAX, ce3m_pkg::PIX_MAX);
        push_frame3(ce3m_pkg::PIX_MAX, 8'd0, 8'd0);
        push_frame3(8'd0, 8'd0, 8'd0);
        wait_drained();
        write_reg(ce3m_pkg::REG_IMAGE_WIDTH, 13'd2);
        write_reg(ce3m_pkg::REG_IMAGE_HEIGHT, 13'd2);
        push_frame3(8'd0, 8'd0, ce3m_pkg::PIX_MAX);
        push_frame3(8'd1, 8'd128, 8'd254);
        wait_drained();

        // above-maximum sizes saturate; the first row gives no result
        write_reg(ce3m_pkg::REG_IMAGE_WIDTH, 13'd2047);
        write_reg(ce3m_pkg::REG_IMAGE_HEIGHT, 13'd8191);
        push_pixels(40, STYLE_NOISE);
        wait_drained();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 67;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            case ($urandom_range(0, 9))
                0: write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                             ce3m_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                1: write_reg(ce3m_pkg::REG_IMAGE_HEIGHT,
                             ce3m_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                2: ;
                default:
                begin
                    write_reg(ce3m_pkg::REG_IMAGE_WIDTH,
                              {2'($urandom_range(0, 3)), 11'($urandom_range(0, 9))});
                    write_reg(ce3m_pkg::REG_IMAGE_HEIGHT,
                              ce3m_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                end
            endcase
            frame_px = eff_width() * eff_height();
            if (frame_px > 64)
                count = eff_width() * $urandom_range(3, 5);
            else
                count = frame_px * $urandom_range(1, 2)
                        + (($urandom_range(0, 2) == 0) ? $urandom_range(1, frame_px - 1) : 0);
            style = pixel_style_t'($urandom_range(0, 2));
            push_pixels(count, style);
            random_items += count;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
